@@ src/shell_quote_tokenizer_assert.svh @@
// Assertion macros shared by the tokenizer modules.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SHELL_QUOTE_TOKENIZER_ASSERT_SVH
`define SHELL_QUOTE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SQT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shell_quote_tokenizer assertion failed");
// Next-cycle implication.
`define SQT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shell_quote_tokenizer assertion failed");
`else
`define SQT_ASSERT_IMP(lbl, ante, cons)
`define SQT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/sqt_pkg.sv @@
package sqt_pkg;

  // Default word limit per string.
  localparam int MaxTokensDefault = 256;

  // Characters with special meaning.
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // One byte of the command string.
  typedef struct packed {
    logic [7:0] ch;
    logic       byte_present;
    logic       last;
  } in_item_t;

  // One result of the tokenizer.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       word_end;
    logic [7:0] word_index;
    logic       string_done;
    logic [8:0] word_count;
  } out_item_t;

  // Lexer modes, one-hot.
  typedef enum logic [5:0] {
    M_BETWEEN = 6'b000001,
    M_WORD    = 6'b000010,
    M_ESC     = 6'b000100,
    M_SQ      = 6'b001000,
    M_DQ      = 6'b010000,
    M_DQESC   = 6'b100000
  } lex_mode_t;

  // Whitespace is space and the range from tab to carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

@@ src/sqt_lexer.sv @@
`include "shell_quote_tokenizer_assert.svh"

module sqt_lexer #(
  parameter int MAX_TOKENS = sqt_pkg::MaxTokensDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  sqt_pkg::in_item_t    item,
  output logic                 has_result,
  output sqt_pkg::out_item_t   result
);
  import sqt_pkg::*;

  localparam int CountW = $clog2(MAX_TOKENS + 1);
  localparam int ExtW   = CountW + 9;

  // Lexer state.
  lex_mode_t          mode;
  lex_mode_t          mode_next;
  lex_mode_t          cur;
  logic [CountW-1:0]  words_seen;
  logic [CountW-1:0]  words_seen_next;
  logic               limit_reached;
  logic               limit_next;

  logic               bv;
  logic               we;
  logic               sd;
  logic [7:0]         ob;
  logic               c_ws;
  logic [ExtW-1:0]    idx_ext;
  logic [ExtW-1:0]    cnt_ext;

  assign c_ws = is_ws(item.ch);

  // One byte of lexing: mode update, byte emission and word closing.
  always_comb begin
    mode_next       = mode;
    words_seen_next = words_seen;
    limit_next      = limit_reached;
    cur             = mode;
    bv              = 1'b0;
    we              = 1'b0;
    sd              = 1'b0;
    ob              = 8'h00;

    if (item.byte_present && !limit_reached) begin
      // A non-blank byte between words opens a word unless the limit is hit.
      if ((mode == M_BETWEEN) && !c_ws) begin
        if (words_seen >= CountW'(MAX_TOKENS)) begin
          limit_next = 1'b1;
        end else begin
          cur = M_WORD;
        end
      end
      mode_next = cur;
      if (!limit_next) begin
        case (cur)
          M_WORD: begin
            if (item.ch == ChSquote) begin
              mode_next = M_SQ;
            end else if (item.ch == ChDquote) begin
              mode_next = M_DQ;
            end else if (item.ch == ChBslash) begin
              if (item.last) begin
                bv = 1'b1;
                ob = item.ch;
              end else begin
                mode_next = M_ESC;
              end
            end else if (c_ws) begin
              we              = 1'b1;
              words_seen_next = words_seen + CountW'(1);
              mode_next       = M_BETWEEN;
            end else begin
              bv = 1'b1;
              ob = item.ch;
            end
          end
          M_ESC: begin
            bv        = 1'b1;
            ob        = item.ch;
            mode_next = M_WORD;
          end
          M_SQ: begin
            if (item.ch == ChSquote) begin
              mode_next = M_WORD;
            end else begin
              bv = 1'b1;
              ob = item.ch;
            end
          end
          M_DQ: begin
            if (item.ch == ChDquote) begin
              mode_next = M_WORD;
            end else if (item.ch == ChBslash) begin
              if (item.last) begin
                bv = 1'b1;
                ob = item.ch;
              end else begin
                mode_next = M_DQESC;
              end
            end else begin
              bv = 1'b1;
              ob = item.ch;
            end
          end
          M_DQESC: begin
            bv        = 1'b1;
            ob        = item.ch;
            mode_next = M_DQ;
          end
          default: begin
          end
        endcase
      end
    end

    // End of string closes any open word; a pending backslash is kept literally.
    if (item.last) begin
      if ((mode_next != M_BETWEEN) && !limit_next) begin
        if (!item.byte_present && ((mode_next == M_ESC) || (mode_next == M_DQESC))) begin
          bv = 1'b1;
          ob = ChBslash;
        end
        we              = 1'b1;
        words_seen_next = words_seen_next + CountW'(1);
      end
      sd = 1'b1;
    end
  end

  // The word index is the count before this byte closed anything; it is zero when only string_done is set.
  assign idx_ext = ExtW'(words_seen);
  assign cnt_ext = ExtW'(words_seen_next);

  assign has_result         = bv || we || sd;
  assign result.byte_valid  = bv;
  assign result.out_byte    = ob;
  assign result.word_end    = we;
  assign result.word_index  = (bv || we) ? idx_ext[7:0] : 8'h00;
  assign result.string_done = sd;
  assign result.word_count  = cnt_ext[8:0];

  // State registers; the end of a string returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_BETWEEN;
      words_seen    <= '0;
      limit_reached <= 1'b0;
    end else if (step) begin
      if (item.last) begin
        mode          <= M_BETWEEN;
        words_seen    <= '0;
        limit_reached <= 1'b0;
      end else begin
        mode          <= mode_next;
        words_seen    <= words_seen_next;
        limit_reached <= limit_next;
      end
    end
  end

  `SQT_ASSERT_IMP(a_count_bound, 1'b1, words_seen <= CountW'(MAX_TOKENS))
  `SQT_ASSERT_IMP(a_limit_between, limit_reached, mode == M_BETWEEN)
  `SQT_ASSERT_NXT(a_end_resets, step && item.last, (words_seen == '0) && (mode == M_BETWEEN) && !limit_reached)

endmodule

@@ src/shell_quote_tokenizer.sv @@
// Shell-style word tokenizer. The command string enters one byte per
// transaction on cmd, with last marking the end of the string; words come
// out on tok as unquoted, unescaped bytes, a word_end marker per word and a
// string_done result carrying the final word count. The block sustains one
// input transaction per clock cycle while tok is not stalled: the lexer
// mode and word count update once per byte. A byte taken on cmd is held in
// the input register and passes through the lexer into the result register
// that drives tok; it stays in the input register while the result
// register is full and not taken. Inputs that produce no result
// (whitespace between words, quotes, escape backslashes) are absorbed
// without an output transaction. Words beyond MAX_TOKENS in one string are
// dropped, and word_index/word_count carry the low bits of the count when
// MAX_TOKENS exceeds their range.
`include "shell_quote_tokenizer_assert.svh"

module shell_quote_tokenizer #(
  parameter int MAX_TOKENS = sqt_pkg::MaxTokensDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sqt_pkg::in_item_t   cmd,
  output logic                tok_valid,
  input  logic                tok_ready,
  output sqt_pkg::out_item_t  tok
);
  import sqt_pkg::*;

  // Input register.
  logic       s1_valid;
  in_item_t   s1_item;
  logic       s1_take;

  // Result register.
  logic       out_valid;
  out_item_t  out_item;
  logic       out_free;

  logic       lex_has_result;
  out_item_t  lex_result;

  assign out_free  = !out_valid || tok_ready;
  assign s1_take   = s1_valid && out_free;
  assign cmd_ready = !s1_valid || out_free;

  // Capture a new byte whenever the input register is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      s1_item <= cmd;
    end
  end

  sqt_lexer #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_take),
    .item      (s1_item),
    .has_result(lex_has_result),
    .result    (lex_result)
  );

  // Result register is loaded only by items that produce a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_take && lex_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && lex_has_result) begin
      out_item <= lex_result;
    end
  end

  assign tok_valid = out_valid;
  assign tok       = out_item;

  `SQT_ASSERT_NXT(a_s1_hold, s1_valid && !out_free, s1_valid && $stable(s1_item))
  `SQT_ASSERT_NXT(a_result_loaded, s1_take && lex_has_result, out_valid)
  `SQT_ASSERT_IMP(a_result_nonempty, tok_valid, tok.byte_valid || tok.word_end || tok.string_done)

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqt_pkg::*;

  localparam int MAX_WORDS = sqt_pkg::MaxTokensDefault;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_ready;
  in_item_t   cmd;
  logic       tok_valid;
  logic       tok_ready;
  out_item_t  tok;

  // Results still owed by the tokenizer, oldest first.
  out_item_t expected_tokens[$];
  int        error_count = 0;

  // Shadow of the lexer state.
  lex_mode_t tracked_mode;
  int        words_closed;
  bit        word_limit_hit;

  // Traffic shaping shared by the sender and the receiver.
  int        tx_gap_pct = 0;
  bit        calm = 1'b0;
  bit        hold_request = 1'b0;

  shell_quote_tokenizer #(
    .MAX_TOKENS(MAX_WORDS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Whitespace is space and the control range from tab to carriage return.
  function automatic bit is_blank(input logic [7:0] c);
    return c inside {ChSpace, [ChTab:ChCr]};
  endfunction

  function automatic void reset_lexer();
    tracked_mode = M_BETWEEN;
    words_closed = 0;
    word_limit_hit = 1'b0;
  endfunction

  // Works out the result, if any, that one accepted transaction causes.
  function automatic void predict_tokens(input in_item_t item);
    out_item_t res;
    bit        emit;
    res = '0;
    emit = 1'b0;
    if (!item.byte_present && !item.last) return;

    if (item.byte_present && !word_limit_hit) begin
      // A non-blank byte between words opens a word unless the limit is hit.
      if (tracked_mode == M_BETWEEN && !is_blank(item.ch)) begin
        if (words_closed >= MAX_WORDS) word_limit_hit = 1'b1;
        else tracked_mode = M_WORD;
      end
      if (!word_limit_hit) begin
        case (tracked_mode)
          M_WORD: begin
            if (item.ch == ChSquote) tracked_mode = M_SQ;
            else if (item.ch == ChDquote) tracked_mode = M_DQ;
            else if (item.ch == ChBslash && !item.last) tracked_mode = M_ESC;
            else if (is_blank(item.ch)) begin
              res.word_end = 1'b1;
              res.word_index = 8'(words_closed);
              words_closed++;
              tracked_mode = M_BETWEEN;
            end else emit = 1'b1;
          end
          M_ESC: begin
            emit = 1'b1;
            tracked_mode = M_WORD;
          end
          M_SQ: begin
            if (item.ch == ChSquote) tracked_mode = M_WORD;
            else emit = 1'b1;
          end
          M_DQ: begin
            if (item.ch == ChDquote) tracked_mode = M_WORD;
            else if (item.ch == ChBslash && !item.last) tracked_mode = M_DQESC;
            else emit = 1'b1;
          end
          M_DQESC: begin
            emit = 1'b1;
            tracked_mode = M_DQ;
          end
          default: begin
          end
        endcase
        if (emit) begin
          res.byte_valid = 1'b1;
          res.out_byte = item.ch;
          res.word_index = 8'(words_closed);
        end
      end
    end

    // End of string: close any open word, flushing a dangling backslash.
    if (item.last) begin
      if (tracked_mode != M_BETWEEN && !word_limit_hit) begin
        if (!item.byte_present && (tracked_mode == M_ESC || tracked_mode == M_DQESC)) begin
          res.byte_valid = 1'b1;
          res.out_byte = ChBslash;
        end
        res.word_end = 1'b1;
        res.word_index = 8'(words_closed);
        words_closed++;
      end
      res.string_done = 1'b1;
    end
    res.word_count = 9'(words_closed);

    if (res.byte_valid || res.word_end || res.string_done) expected_tokens.push_back(res);
    if (item.last) reset_lexer();
  endfunction

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every output transaction with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && tok_valid && tok_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result transaction %h", tok);
        error_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("byte_valid", 9'(want.byte_valid), 9'(tok.byte_valid));
        check_field("out_byte", 9'(want.out_byte), 9'(tok.out_byte));
        check_field("word_end", 9'(want.word_end), 9'(tok.word_end));
        check_field("word_index", 9'(want.word_index), 9'(tok.word_index));
        check_field("string_done", 9'(want.string_done), 9'(tok.string_done));
        check_field("word_count", want.word_count, tok.word_count);
      end
    end
  end

  // Receiver: random stall bursts whose rate changes from phase to phase,
  // plus one long hold-off on request.
  initial begin
    int stall_pct;
    int phase_left;
    stall_pct = 0;
    phase_left = 0;
    tok_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        tok_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        tok_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        tok_ready <= 1'b1;
        @(posedge clk);
      end
      phase_left--;
      if (phase_left <= 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 25;
        endcase
        phase_left = $urandom_range(20, 80);
      end
    end
  end

  // Offers one input transaction and waits until it is taken.
  task automatic send_item(input in_item_t item);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd <= item;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    predict_tokens(item);
  endtask

  // Sends a command string; it ends either with last on its final byte or
  // with a separate end-of-string transaction that carries no byte.
  task automatic send_bytes(input logic [7:0] text[$], input bit end_marker,
                            input bit fillers);
    in_item_t item;
    for (int i = 0; i < text.size(); i++) begin
      if (fillers && $urandom_range(0, 19) == 0) begin
        item.ch = 8'($urandom_range(0, 255));
        item.byte_present = 1'b0;
        item.last = 1'b0;
        send_item(item);
      end
      item.ch = text[i];
      item.byte_present = 1'b1;
      item.last = !end_marker && (i == text.size() - 1);
      send_item(item);
    end
    if (end_marker || text.size() == 0) begin
      item.ch = 8'($urandom_range(0, 255));
      item.byte_present = 1'b0;
      item.last = 1'b1;
      send_item(item);
    end
  endtask

  task automatic send_text(input string s, input bit end_marker);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_bytes(text, end_marker, 1'b0);
  endtask

  // Stops offering input until every owed result has come out.
  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_blank(c) || c == ChSquote || c == ChDquote || c == ChBslash);
    return c;
  endfunction

  function automatic logic [7:0] char_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 1) == 0) return ChSpace;
    return 8'($urandom_range(ChTab, ChCr));
  endfunction

  // One word built from plain runs, quoted parts and escapes.
  function automatic void append_word(ref logic [7:0] text[$]);
    int pieces;
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      case ($urandom_range(0, 5))
        1: begin
          text.push_back(ChSquote);
          repeat ($urandom_range(0, 4)) text.push_back(char_except(ChSquote, ChSquote));
          text.push_back(ChSquote);
        end
        2: begin
          text.push_back(ChDquote);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
              text.push_back(ChBslash);
              text.push_back(8'($urandom_range(0, 255)));
            end else text.push_back(char_except(ChDquote, ChBslash));
          end
          text.push_back(ChDquote);
        end
        3: begin
          text.push_back(ChBslash);
          text.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          text.push_back($urandom_range(0, 1) ? ChSquote : ChDquote);
          text.push_back(text[text.size() - 1]);
        end
        default: repeat ($urandom_range(1, 4)) text.push_back(plain_char());
      endcase
    end
  endfunction

  // A random command string: mostly well-formed words, sometimes raw noise,
  // often with an open quote or a dangling backslash at the end.
  function automatic void build_command(ref logic [7:0] text[$]);
    int words;
    text.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    words = $urandom_range(0, 6);
    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 2)) text.push_back(blank_char());
    for (int w = 0; w < words; w++) begin
      if (w != 0) repeat ($urandom_range(1, 3)) text.push_back(blank_char());
      append_word(text);
    end
    case ($urandom_range(0, 5))
      0: text.push_back(blank_char());
      1: text.push_back(ChBslash);
      2: text.push_back(ChSquote);
      3: text.push_back(ChDquote);
      default: begin
      end
    endcase
  endfunction

  // Byte values 0x00 and 0xFF inside a word, and an empty string.
  task automatic test_field_extremes();
    send_item('{ch: 8'h00, byte_present: 1'b1, last: 1'b0});
    send_item('{ch: 8'hFF, byte_present: 1'b1, last: 1'b0});
    send_item('{ch: 8'hFF, byte_present: 1'b0, last: 1'b1});
    send_item('{ch: 8'h00, byte_present: 1'b0, last: 1'b1});
  endtask

  // Empty single and double quoted words, then an unclosed single quote.
  task automatic test_quoting();
    send_text("''\t\"\" 'a", 1'b0);
  endtask

  // Escaped space, escaped quote inside double quotes, a backslash on the
  // last byte, and strings that end right after an escaping backslash.
  task automatic test_escapes();
    send_text("\\ \"\\\"\" \\", 1'b0);
    send_text("\"\\", 1'b1);
    send_text("q\\", 1'b1);
  endtask

  // A transaction with no byte and no end, a word closed by whitespace on
  // the last byte, and a string of whitespace only.
  task automatic test_string_ends();
    send_item('{ch: "r", byte_present: 1'b1, last: 1'b0});
    send_item('{ch: 8'($urandom_range(0, 255)), byte_present: 1'b0, last: 1'b0});
    send_item('{ch: 8'h0B, byte_present: 1'b1, last: 1'b1});
    send_text(" \t", 1'b1);
  endtask

  // Sender waits for the tokenizer to drain after each string.
  task automatic test_sender_pause();
    logic [7:0] text[$];
    repeat (4) begin
      build_command(text);
      send_bytes(text, 1'b1, 1'b0);
      wait_for_results();
    end
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // tokenizer backs up and stalls its input.
  task automatic test_receiver_hold();
    logic [7:0] text[$];
    repeat (40) text.push_back(plain_char());
    hold_request = 1'b1;
    send_bytes(text, 1'b0, 1'b0);
    wait_for_results();
  endtask

  // Strings at and beyond the word limit.
  task automatic test_word_limit();
    logic [7:0] text[$];
    // Past the limit everything, quotes and backslashes too, is dropped.
    for (int w = 0; w < MAX_WORDS + 2; w++) begin
      repeat ($urandom_range(1, 2)) text.push_back(plain_char());
      text.push_back(blank_char());
    end
    text.push_back(ChSquote);
    text.push_back(ChBslash);
    send_bytes(text, 1'b1, 1'b0);
    // Exactly the limit, the final word closed by the end of the string.
    text.delete();
    for (int w = 0; w < MAX_WORDS; w++) begin
      if (w != 0) text.push_back(blank_char());
      text.push_back(plain_char());
    end
    send_bytes(text, 1'b0, 1'b0);
  endtask

  task automatic test_random_strings(input int n_items);
    logic [7:0] text[$];
    bit         end_marker;
    int         sent;
    sent = 0;
    while (sent < n_items) begin
      build_command(text);
      end_marker = 1'($urandom_range(0, 1));
      if (!calm) begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 10;
          default: tx_gap_pct = 35;
        endcase
      end
      send_bytes(text, end_marker, 1'b1);
      sent += text.size() + ((end_marker || text.size() == 0) ? 1 : 0);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    reset_lexer();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_gap_pct = 20;
    test_field_extremes();
    test_quoting();
    test_escapes();
    test_string_ends();
    test_sender_pause();
    test_receiver_hold();
    test_word_limit();
    test_random_strings(280);

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    tx_gap_pct = 0;
    test_random_strings(140);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ shell_quote_tokenizer.f @@
+incdir+src
src/sqt_pkg.sv
src/sqt_lexer.sv
src/shell_quote_tokenizer.sv
tb/tb.sv
